// ===== hw/rtl/dadn_pkg.sv =====
// Shared types, state encoding and calendar tables for the date-advance block.
// Used by dadn_ctrl, dadn_dp and date_add_days_and_day_number.
`timescale 1ns / 1ps

package dadn_pkg;

   // Internal widths cover the default parameter ranges (year up to 9999, offset up to 4095).
   localparam int YEAR_W = 17;
   localparam int DAY_W  = 13;
   localparam int QUO_W  = 10;
   localparam int REM_W  = 7;
   localparam int CNT_W  = 22;

   // floor(y/100) estimate: (y * RECIP_100) >> RECIP_SHIFT, low by at most one
   localparam int RECIP_100   = 5242;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = 30;

   localparam int DAYS_PER_YEAR = 365;
   localparam int MONTHS        = 12;

   typedef struct packed {
      logic [13:0] start_year;
      logic [3:0]  start_month;
      logic [4:0]  start_day;
      logic [11:0] offset_days;
   } req_type;

   typedef struct packed {
      logic [13:0] norm_year;
      logic [3:0]  norm_month;
      logic [4:0]  norm_day;
      logic [21:0] day_number;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SPLIT,
      ST_STEP,
      ST_SUM,
      ST_ACC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic split;
      logic step;
      logic sum;
      logic acc;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic over;
      logic out_free;
   } sts_type;

   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
      logic [4:0] len;
      unique case (month)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   // days in the months before this one
   function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] month);
      logic [8:0] base;
      unique case (month)
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      return (leap && month > 4'd2) ? base + 9'd1 : base;
   endfunction

endpackage

// ===== hw/rtl/dadn_ctrl.sv =====
// Sequencer for the date-advance block: accept, split year, month steps, sum, emit.
// Depends on dadn_pkg; drives the command struct of dadn_dp.
`timescale 1ns / 1ps

module dadn_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dadn_pkg::sts_type sts,
   output dadn_pkg::cmd_type cmd
);
   import dadn_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_MUL;
         ST_MUL:   state_in = ST_SPLIT;
         ST_SPLIT: state_in = ST_STEP;
         ST_STEP:  if (!sts.over) state_in = ST_SUM;
         ST_SUM:   state_in = ST_ACC;
         ST_ACC:   state_in = ST_EMIT;
         ST_EMIT:  if (sts.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE:  cmd.load  = req_valid;
         ST_MUL:   cmd.mul   = 1'b1;
         ST_SPLIT: cmd.split = 1'b1;
         ST_STEP:  cmd.step  = sts.over;
         ST_SUM:   cmd.sum   = 1'b1;
         ST_ACC:   cmd.acc   = 1'b1;
         ST_EMIT:  cmd.emit  = sts.out_free;
         default:  cmd       = '0;
      endcase
   end

endmodule

// ===== hw/rtl/dadn_dp.sv =====
// Datapath for the date-advance block: clamps, year split by 100, month stepping,
// day count and the result register. Depends on dadn_pkg; commanded by dadn_ctrl.
`timescale 1ns / 1ps

module dadn_dp #(
   parameter int YEAR_MAX   = 9999,
   parameter int OFFSET_MAX = 4095
) (
   input  logic              clock,
   input  logic              reset,
   input  dadn_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dadn_pkg::rsp_type rsp_data,
   input  dadn_pkg::cmd_type cmd,
   output dadn_pkg::sts_type sts
);
   import dadn_pkg::*;

   logic [YEAR_W-1:0] year_ff, year_in;
   logic [3:0]        month_ff, month_in;
   logic [DAY_W-1:0]  day_ff, day_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0] prod_ff;
   logic [CNT_W-1:0]  yr_days_ff, leaps_ff, count_ff;
   logic [8:0]        prefix_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   // input conditioning
   logic [YEAR_W-1:0] y_clamp, y_start;
   logic [11:0]       off_clamp;
   logic [3:0]        m_start;
   logic [DAY_W-1:0]  d_sum, d_start;

   always_comb begin
      y_clamp = ({3'b0, req_data.start_year} > YEAR_W'(YEAR_MAX)) ?
                YEAR_W'(YEAR_MAX) : {3'b0, req_data.start_year};
      off_clamp = ({4'b0, req_data.offset_days} > 16'(OFFSET_MAX)) ?
                  12'(OFFSET_MAX) : req_data.offset_days;
      y_start = y_clamp;
      m_start = req_data.start_month;
      if (req_data.start_month == 4'd0) begin
         m_start = 4'd1;
      end else if (req_data.start_month > 4'(MONTHS)) begin
         m_start = req_data.start_month - 4'(MONTHS);
         y_start = y_clamp + 1'b1;
      end
      d_sum   = DAY_W'(req_data.start_day) + DAY_W'(off_clamp);
      d_start = (d_sum == '0) ? DAY_W'(1) : d_sum;
   end

   // year split into quotient and remainder by 100
   logic [QUO_W-1:0]  q_est;
   logic [YEAR_W-1:0] r_est;

   assign q_est = prod_ff[RECIP_SHIFT +: QUO_W];
   assign r_est = year_ff - YEAR_W'(q_est) * YEAR_W'(100);

   logic       leap;
   logic [4:0] len;

   assign leap = (rem_ff == '0) ? (quo_ff[1:0] == 2'b00) : (rem_ff[1:0] == 2'b00);
   assign len  = month_len(leap, month_ff);

   // leap years before the current year, from p = year - 1 = 100*pq + pr
   logic [QUO_W-1:0] pq;
   logic [REM_W-1:0] pr;
   logic [CNT_W-1:0] leaps_calc;

   always_comb begin
      if (rem_ff != '0) begin
         pq = quo_ff;
         pr = rem_ff - 1'b1;
      end else begin
         pq = quo_ff - 1'b1;
         pr = REM_W'(99);
      end
      if (year_ff == '0) begin
         leaps_calc = '0;
      end else begin
         leaps_calc = CNT_W'({pq, 4'b0}) + CNT_W'({pq, 3'b0}) + CNT_W'(pr >> 2)
                    + CNT_W'(pq >> 2) + CNT_W'(1);
      end
   end

   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (cmd.load) begin
         year_in  = y_start;
         month_in = m_start;
         day_in   = d_start;
      end
      if (cmd.split) begin
         if (r_est >= YEAR_W'(100)) begin
            quo_in = q_est + 1'b1;
            rem_in = REM_W'(r_est - YEAR_W'(100));
         end else begin
            quo_in = q_est;
            rem_in = REM_W'(r_est);
         end
      end
      if (cmd.step) begin
         day_in = day_ff - DAY_W'(len);
         if (month_ff == 4'(MONTHS)) begin
            month_in = 4'd1;
            year_in  = year_ff + 1'b1;
            if (rem_ff == REM_W'(99)) begin
               rem_in = '0;
               quo_in = quo_ff + 1'b1;
            end else begin
               rem_in = rem_ff + 1'b1;
            end
         end else begin
            month_in = month_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      year_ff  <= year_in;
      month_ff <= month_in;
      day_ff   <= day_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      if (cmd.mul) begin
         prod_ff <= PROD_W'(year_ff) * PROD_W'(RECIP_100);
      end
      if (cmd.sum) begin
         yr_days_ff <= CNT_W'(year_ff) * CNT_W'(DAYS_PER_YEAR);
         leaps_ff   <= leaps_calc;
         prefix_ff  <= cum_days(leap, month_ff);
      end
      if (cmd.acc) begin
         count_ff <= yr_days_ff + leaps_ff + CNT_W'(prefix_ff) + CNT_W'(day_ff);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.norm_year  <= year_ff[13:0];
         rsp_data_ff.norm_month <= month_ff;
         rsp_data_ff.norm_day   <= day_ff[4:0];
         rsp_data_ff.day_number <= count_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign sts.over     = (day_ff > DAY_W'(len));
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   a_step_month: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (month_ff >= 4'd1 && month_ff <= 4'(MONTHS)))
      else $error("month out of range while stepping");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.sum) |-> (rem_ff < REM_W'(100)))
      else $error("year remainder not below 100");

   a_split_exact: assert property (@(posedge clock) disable iff (reset)
      cmd.split |=> (YEAR_W'(quo_ff) * YEAR_W'(100) + YEAR_W'(rem_ff) == year_ff))
      else $error("year split does not rebuild the year");

   a_emit_norm: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (day_ff >= DAY_W'(1) && day_ff <= DAY_W'(31)))
      else $error("emitted day not normalized");

endmodule

// ===== hw/rtl/date_add_days_and_day_number.sv =====
// Top level of the date-advance block: adds a day offset to a date, normalizes it
// and returns its day count from year 0. Depends on dadn_pkg, dadn_ctrl and dadn_dp.
//
//   channel  dir  handshake                     beat
//   req      in   req_valid / req_stall         start_year, start_month, start_day, offset_days
//   rsp      out  rsp_valid / rsp_stall         norm_year, norm_month, norm_day, day_number
//
// One item at a time: an accepted beat passes the multiply, split, month-step, sum, accumulate
// and emit states, stepping one month per cycle (up to about 140 months for offset 4095).
// req_stall is high from acceptance until the result is written to the output register.
// The output register holds a result under rsp_stall while the next item is processed.
// Synchronous active-high reset clears the sequencer and the output valid.
`timescale 1ns / 1ps

module date_add_days_and_day_number #(
   parameter int YEAR_MAX   = 9999,
   parameter int OFFSET_MAX = 4095
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dadn_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dadn_pkg::rsp_type rsp_data
);
   import dadn_pkg::*;

   cmd_type cmd;
   sts_type sts;

   dadn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dadn_dp #(
      .YEAR_MAX   (YEAR_MAX),
      .OFFSET_MAX (OFFSET_MAX)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ===== tb/sv/dadn_date_checker.sv =====
// Scoreboard for the date-advance block: predicts each result from the accepted
// request beat and compares it with the response beat. Depends on dadn_pkg.
`timescale 1ns / 1ps

module dadn_date_checker #(
   parameter int YEAR_MAX   = 9999,
   parameter int OFFSET_MAX = 4095
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  dadn_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  dadn_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending,
   output int                checked
);
   import dadn_pkg::*;

   rsp_type expected_dates[$];

   function automatic bit is_leap_year(input int unsigned yr);
      return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
   endfunction

   function automatic int unsigned days_in_month(input int unsigned yr, input int unsigned mo);
      case (mo)
         2: begin
            return is_leap_year(yr) ? 29 : 28;
         end
         4, 6, 9, 11: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   function automatic rsp_type advance_date(input req_type beat);
      int unsigned yr, mo, dy, ofs, total, prev, m;
      rsp_type res;
      yr  = beat.start_year;
      mo  = beat.start_month;
      dy  = beat.start_day;
      ofs = beat.offset_days;
      if (yr > YEAR_MAX) yr = YEAR_MAX;
      if (ofs > OFFSET_MAX) ofs = OFFSET_MAX;
      if (mo == 0) mo = 1;
      // months 13..15 roll into the next year
      if (mo > MONTHS) begin
         mo = mo - MONTHS;
         yr = yr + 1;
      end
      dy = dy + ofs;
      if (dy == 0) dy = 1;
      while (dy > days_in_month(yr, mo)) begin
         dy = dy - days_in_month(yr, mo);
         mo = mo + 1;
         if (mo > MONTHS) begin
            mo = 1;
            yr = yr + 1;
         end
      end
      total = yr * DAYS_PER_YEAR;
      // year 0 is leap, so every year 1.. has one extra leap before it
      if (yr != 0) begin
         prev  = yr - 1;
         total = total + prev / 4 - prev / 100 + prev / 400 + 1;
      end
      for (m = 1; m < mo; m++) total = total + days_in_month(yr, m);
      total = total + dy;
      res.norm_year  = 14'(yr);
      res.norm_month = 4'(mo);
      res.norm_day   = 5'(dy);
      res.day_number = 22'(total);
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int errs;
      errs = 0;
      if (reset) begin
         expected_dates.delete();
         fail_count <= 0;
         checked    <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_dates.size() == 0) begin
               $error("unexpected response beat %p", rsp_data);
               errs++;
            end else begin
               want = expected_dates.pop_front();
               if (rsp_data.norm_year !== want.norm_year) begin
                  $error("norm_year: expected %0d, got %0d", want.norm_year, rsp_data.norm_year);
                  errs++;
               end
               if (rsp_data.norm_month !== want.norm_month) begin
                  $error("norm_month: expected %0d, got %0d",
                         want.norm_month, rsp_data.norm_month);
                  errs++;
               end
               if (rsp_data.norm_day !== want.norm_day) begin
                  $error("norm_day: expected %0d, got %0d", want.norm_day, rsp_data.norm_day);
                  errs++;
               end
               if (rsp_data.day_number !== want.day_number) begin
                  $error("day_number: expected %0d, got %0d",
                         want.day_number, rsp_data.day_number);
                  errs++;
               end
            end
            checked <= checked + 1;
         end
         if (req_valid && !req_stall) begin
            expected_dates.insert(expected_dates.size(), advance_date(req_data));
         end
         fail_count <= fail_count + errs;
      end
      pending <= expected_dates.size();
   end

endmodule

// ===== tb/sv/tb_date_add_days_and_day_number.sv =====
// Testbench top for date_add_days_and_day_number: clock, reset, request stimulus,
// random response back-pressure and the verdict. Depends on dadn_pkg and dadn_date_checker.
`timescale 1ns / 1ps

module tb_date_add_days_and_day_number;
   import dadn_pkg::*;

   localparam int YEAR_LIMIT   = 9999;
   localparam int OFFSET_LIMIT = 4095;
   localparam int RANDOM_BEATS = 700;
   localparam int CYCLE_LIMIT  = 800000;
   localparam int DRAIN_CYCLES = 200;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count, pending, checked;
   int cycle_count   = 0;
   int stall_left    = 0;
   int directed_sent = 0;
   int random_sent   = 0;
   int long_offsets  = 0;
   bit quiet         = 1'b0;

   date_add_days_and_day_number #(
      .YEAR_MAX  (YEAR_LIMIT),
      .OFFSET_MAX(OFFSET_LIMIT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   dadn_date_checker #(
      .YEAR_MAX  (YEAR_LIMIT),
      .OFFSET_MAX(OFFSET_LIMIT)
   ) date_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .fail_count(fail_count),
      .pending   (pending),
      .checked   (checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // back-pressure in segments: mostly short, now and then a long stall
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 9);
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= $urandom_range(1, 8);
      end else if (r < 6) begin
         rsp_stall  <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else if (r < 9) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(20, 80);
      end
   end

   function automatic req_type make_date(input int yr, input int mo, input int dy, input int ofs);
      req_type beat;
      beat.start_year  = 14'(yr);
      beat.start_month = 4'(mo);
      beat.start_day   = 5'(dy);
      beat.offset_days = 12'(ofs);
      return beat;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // valid stays high across back-to-back beats; it only drops for a gap
   task automatic send_date(input req_type beat);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // directed beats go out in the order listed, with the same random gaps as the rest
   task automatic send_directed(input req_type beat);
      send_date(beat);
      directed_sent++;
   endtask

   function automatic req_type random_date();
      int r, yr, mo, dy, ofs;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         // raw fields: covers out-of-range years, month 0 and 13..15, day 0
         return make_date($urandom, $urandom, $urandom, $urandom);
      end
      yr = $urandom_range(0, YEAR_LIMIT);
      if ($urandom_range(0, 9) == 0) yr = 100 * $urandom_range(0, 99) + $urandom_range(0, 1) - 1;
      if (yr < 0) yr = 0;
      mo = $urandom_range(1, 12);
      dy = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 28) : $urandom_range(29, 31);
      r  = $urandom_range(0, 99);
      if (r < 50) ofs = $urandom_range(0, 63);
      else if (r < 85) ofs = $urandom_range(0, 1000);
      else ofs = $urandom_range(0, OFFSET_LIMIT);
      return make_date(yr, mo, dy, ofs);
   endfunction

   initial begin
      req_type beat;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_directed(make_date(0, 1, 1, 0));
      send_directed(make_date(9999, 12, 31, 4095));
      send_directed(make_date(16383, 15, 31, 4095));
      send_directed(make_date(10000, 6, 15, 10));
      send_directed(make_date(2023, 0, 10, 0));
      send_directed(make_date(2023, 13, 1, 0));
      send_directed(make_date(2023, 14, 30, 0));
      send_directed(make_date(9999, 15, 31, 0));
      send_directed(make_date(2023, 5, 0, 0));
      send_directed(make_date(2023, 5, 0, 5));
      send_directed(make_date(2023, 2, 31, 0));
      send_directed(make_date(2000, 2, 28, 1));
      send_directed(make_date(1900, 2, 28, 1));
      send_directed(make_date(0, 2, 28, 1));
      send_directed(make_date(2024, 2, 29, 0));
      send_directed(make_date(2023, 12, 31, 1));
      send_directed(make_date(1999, 12, 31, 366));
      send_directed(make_date(399, 3, 1, 365));
      send_directed(make_date(0, 0, 0, 0));
      send_directed(make_date(1, 1, 1, 4095));
      send_directed(make_date(9998, 11, 30, 2048));

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         // every 100 beats pick a pressured or, one time in three, a gap-free stretch
         if (n % 100 == 0) quiet = ($urandom_range(0, 2) == 0);
         beat = random_date();
         if (beat.offset_days > 1000) long_offsets++;
         send_date(beat);
         random_sent++;
      end
      req_valid <= 1'b0;

      // let the checker count the last accepted beat before waiting on it
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d date beats (%0d directed, %0d random, %0d with offsets over 1000).",
               directed_sent + random_sent, directed_sent, random_sent, long_offsets);
      $display("Checked %0d results under random gaps and response stalls.", checked);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count, pending);
      $display("Regression FAIL");
      $finish;
   end

endmodule
